[hw/rtl/cbm_pkg.sv]
package cbm_pkg;

    localparam int CBM_PIXEL_COUNT = 65536;
    localparam int CBM_MAX_WORDS   = 8;

    typedef enum logic [1:0] {
        REQ_UPDATE  = 2'd0,
        REQ_DIFF    = 2'd1,
        REQ_CLEAR   = 2'd2,
        REQ_ADVANCE = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        REG_LEARN_MARGINS = 2'd0,
        REG_MATCH_LOW     = 2'd1,
        REG_MATCH_HIGH    = 2'd2,
        REG_STALE_THRESH  = 2'd3
    } reg_index_t;

    localparam logic [23:0] LEARN_MARGINS_RST = 24'h0A0A0A;
    localparam logic [23:0] MATCH_LOW_RST     = 24'h010103;
    localparam logic [23:0] MATCH_HIGH_RST    = 24'h01010A;
    localparam logic [30:0] STALE_THRESH_RST  = 31'd0;

    typedef struct packed {
        logic [2:0][7:0] learn_min;
        logic [2:0][7:0] learn_max;
        logic [2:0][7:0] box_min;
        logic [2:0][7:0] box_max;
        logic [31:0]     last_update;
        logic [31:0]     staleness;
    } codeword_t;

endpackage

[hw/rtl/cbm_req_if.sv]
interface cbm_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] pixel_index;
    logic [7:0]  chan0;
    logic [7:0]  chan1;
    logic [7:0]  chan2;
    logic        masked_out;

    modport source (output valid, req_type, pixel_index, chan0, chan1, chan2, masked_out,
                    input ready);
    modport sink (input valid, req_type, pixel_index, chan0, chan1, chan2, masked_out,
                  output ready);
endinterface

[hw/rtl/cbm_res_if.sv]
interface cbm_res_if;
    logic       valid;
    logic       ready;
    logic       foreground;
    logic       status;
    logic [6:0] words_in_pixel;

    modport source (output valid, foreground, status, words_in_pixel, input ready);
    modport sink (input valid, foreground, status, words_in_pixel, output ready);
endinterface

[hw/rtl/cbm_cfg_if.sv]
interface cbm_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  reg_index;
    logic [31:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

[hw/rtl/codebook_background_model_core.sv]
// Per-pixel codebook background model. Each request beat is accepted, then a read state
// performs the synchronous read of the pixel's codebook word (all codeword slots side by
// side) and its count, then a compute state computes, writes back and loads the result
// register. One request is in flight at a time; a result waiting in the output register
// holds the next compute step. After reset a clearing pass zeroes every pixel's count,
// during which no request is accepted; configuration writes are taken at all times.
module codebook_background_model_core
    import cbm_pkg::*;
#(
    parameter int PIXEL_COUNT = CBM_PIXEL_COUNT,
    parameter int MAX_WORDS   = CBM_MAX_WORDS
) (
    input  logic clk,
    input  logic rst_n,
    cbm_cfg_if.sink   cfg,
    cbm_req_if.sink   req,
    cbm_res_if.source res
);

    localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int CW = $clog2(MAX_WORDS + 1);

    typedef enum logic [1:0] {
        ST_CLR,
        ST_IDLE,
        ST_READ,
        ST_CALC
    } state_t;

    state_t state_reg;

    logic [23:0] learn_m_reg;
    logic [23:0] match_lo_reg;
    logic [23:0] match_hi_reg;
    logic [30:0] thresh_reg;
    logic [31:0] ftime_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [1:0]  rtype_reg;
    logic [15:0] pix_reg;
    logic [2:0][7:0] p_reg;
    logic        masked_reg;

    codeword_t [MAX_WORDS-1:0] cw_mem [PIXEL_COUNT];
    logic [CW-1:0]             cnt_mem [PIXEL_COUNT];
    codeword_t [MAX_WORDS-1:0] cw_rd_reg;
    logic [CW-1:0]             cnt_rd_reg;

    logic       out_valid_reg;
    logic       out_fg_reg;
    logic       out_status_reg;
    logic [6:0] out_words_reg;

    logic [AW-1:0] addr;
    logic          pix_ok;
    logic          proceed;
    logic          mem_we;
    logic          cnt_we;
    logic [AW-1:0] cnt_waddr;
    logic [CW-1:0] cnt_wdata;

    codeword_t [MAX_WORDS-1:0] upd_cw;
    codeword_t [MAX_WORDS-1:0] new_cw;
    codeword_t [MAX_WORDS-1:0] clr_cw;
    codeword_t                 fresh;
    logic [CW-1:0]             new_cnt;
    logic [CW-1:0]             keep_cnt;
    logic [CW-1:0]             pos [MAX_WORDS];
    logic [MAX_WORDS-1:0]      keep;
    logic [MAX_WORDS-1:0]      box_ok;
    logic                      found;
    logic                      in_range;
    logic                      box_hit;
    logic                      calc_fg;
    logic                      calc_status;
    logic [2:0][7:0]           lo;
    logic [2:0][7:0]           hi;
    logic [8:0]                sum9;
    logic [31:0]               run;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign res.valid = out_valid_reg;
    assign res.foreground = out_fg_reg;
    assign res.status = out_status_reg;
    assign res.words_in_pixel = out_words_reg;

    assign addr    = AW'(pix_reg);
    assign pix_ok  = {16'd0, pix_reg} < 32'(PIXEL_COUNT);
    assign proceed = (state_reg == ST_CALC) && (!out_valid_reg || res.ready);

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            lo[c] = (p_reg[c] > learn_m_reg[8*c +: 8]) ? p_reg[c] - learn_m_reg[8*c +: 8] : 8'd0;
            sum9  = {1'b0, p_reg[c]} + {1'b0, learn_m_reg[8*c +: 8]};
            hi[c] = sum9[8] ? 8'hFF : sum9[7:0];
        end
        fresh.learn_min   = lo;
        fresh.learn_max   = hi;
        fresh.box_min     = p_reg;
        fresh.box_max     = p_reg;
        fresh.last_update = ftime_reg;
        fresh.staleness   = 32'd0;

        found  = 1'b0;
        upd_cw = cw_rd_reg;
        box_ok = '0;
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            in_range = (CW'(w) < cnt_rd_reg);
            box_hit  = in_range;
            for (int c = 0; c < 3; c++)
            begin
                if (cw_rd_reg[w].learn_min[c] > p_reg[c] || p_reg[c] > cw_rd_reg[w].learn_max[c])
                begin
                    in_range = 1'b0;
                end
                if ({1'b0, cw_rd_reg[w].box_min[c]} > {1'b0, p_reg[c]} + {1'b0, match_lo_reg[8*c +: 8]}
                    || {1'b0, p_reg[c]} > {1'b0, cw_rd_reg[w].box_max[c]} + {1'b0, match_hi_reg[8*c +: 8]})
                begin
                    box_hit = 1'b0;
                end
            end
            box_ok[w] = box_hit;
            run = ftime_reg - cw_rd_reg[w].last_update;
            if (in_range && !found)
            begin
                found = 1'b1;
                upd_cw[w].last_update = ftime_reg;
                for (int c = 0; c < 3; c++)
                begin
                    if (p_reg[c] < cw_rd_reg[w].box_min[c])
                    begin
                        upd_cw[w].box_min[c] = p_reg[c];
                    end
                    if (p_reg[c] > cw_rd_reg[w].box_max[c])
                    begin
                        upd_cw[w].box_max[c] = p_reg[c];
                    end
                    if (cw_rd_reg[w].learn_min[c] > lo[c])
                    begin
                        upd_cw[w].learn_min[c] = cw_rd_reg[w].learn_min[c] - 8'd1;
                    end
                    if (cw_rd_reg[w].learn_max[c] < hi[c])
                    begin
                        upd_cw[w].learn_max[c] = cw_rd_reg[w].learn_max[c] + 8'd1;
                    end
                end
            end
            else if (CW'(w) < cnt_rd_reg && run > cw_rd_reg[w].staleness)
            begin
                upd_cw[w].staleness = run;
            end
        end

        keep_cnt = '0;
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            keep[w] = (CW'(w) < cnt_rd_reg)
                      && (cw_rd_reg[w].staleness <= {1'b0, thresh_reg});
            pos[w]  = keep_cnt;
            keep_cnt = keep_cnt + CW'(keep[w]);
        end
        clr_cw = cw_rd_reg;
        for (int j = 0; j < MAX_WORDS; j++)
        begin
            for (int w = j; w < MAX_WORDS; w++)
            begin
                if (keep[w] && pos[w] == CW'(j))
                begin
                    clr_cw[j] = cw_rd_reg[w];
                    clr_cw[j].staleness = 32'd0;
                    clr_cw[j].last_update = ftime_reg;
                end
            end
        end

        calc_fg     = 1'b0;
        calc_status = 1'b0;
        new_cw      = upd_cw;
        new_cnt     = cnt_rd_reg;
        mem_we      = 1'b0;
        case (req_type_t'(rtype_reg))
            REQ_UPDATE:
            begin
                mem_we = pix_ok && !masked_reg;
                if (!found)
                begin
                    if (cnt_rd_reg == CW'(MAX_WORDS))
                    begin
                        calc_status = pix_ok && !masked_reg;
                    end
                    else
                    begin
                        new_cw[0] = fresh;
                        for (int w = 1; w < MAX_WORDS; w++)
                        begin
                            new_cw[w] = upd_cw[w-1];
                        end
                        new_cnt = cnt_rd_reg + CW'(1);
                    end
                end
            end
            REQ_DIFF:
            begin
                calc_fg = !pix_ok || !(|box_ok);
            end
            REQ_CLEAR:
            begin
                mem_we  = pix_ok && !masked_reg;
                new_cw  = clr_cw;
                new_cnt = keep_cnt;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase

        if (state_reg == ST_CLR)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = clr_addr_reg;
            cnt_wdata = '0;
        end
        else
        begin
            cnt_we    = proceed && mem_we;
            cnt_waddr = addr;
            cnt_wdata = new_cnt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
        begin
            cw_rd_reg  <= cw_mem[addr];
            cnt_rd_reg <= cnt_mem[addr];
        end
        if (proceed && mem_we)
        begin
            cw_mem[addr] <= new_cw;
        end
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            rtype_reg  <= req.req_type;
            pix_reg    <= req.pixel_index;
            p_reg      <= {req.chan2, req.chan1, req.chan0};
            masked_reg <= req.masked_out;
        end
        if (proceed)
        begin
            out_fg_reg     <= calc_fg;
            out_status_reg <= calc_status;
            out_words_reg  <= pix_ok ? 7'(mem_we ? new_cnt : cnt_rd_reg) : 7'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            clr_addr_reg  <= '0;
            ftime_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            learn_m_reg   <= LEARN_MARGINS_RST;
            match_lo_reg  <= MATCH_LOW_RST;
            match_hi_reg  <= MATCH_HIGH_RST;
            thresh_reg    <= STALE_THRESH_RST;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (reg_index_t'(cfg.reg_index))
                    REG_LEARN_MARGINS: learn_m_reg  <= cfg.wdata[23:0];
                    REG_MATCH_LOW:     match_lo_reg <= cfg.wdata[23:0];
                    REG_MATCH_HIGH:    match_hi_reg <= cfg.wdata[23:0];
                    REG_STALE_THRESH:  thresh_reg   <= cfg.wdata[30:0];
                    default:           thresh_reg   <= thresh_reg;
                endcase
            end

            if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLR:
                begin
                    clr_addr_reg <= clr_addr_reg + AW'(1);
                    if (clr_addr_reg == AW'(PIXEL_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    if (proceed)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (req_type_t'(rtype_reg) == REQ_ADVANCE)
                        begin
                            ftime_reg <= ftime_reg + 32'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[tb/tb_codebook_checker.sv]
`timescale 1ns / 1ps

module tb_codebook_checker
    import cbm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    cbm_cfg_if   cfg,
    cbm_req_if   req,
    cbm_res_if   res,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic       fg;
        logic       st;
        logic [6:0] words;
    } pixel_result_t;

    pixel_result_t result_q[$];

    logic [23:0] learn_m;
    logic [23:0] low_m;
    logic [23:0] high_m;
    logic [30:0] stale_lim;
    logic [31:0] now;
    logic [3:0]  count_of[int];
    codeword_t   book[int];

    assign pending = result_q.size();

    function automatic int clip8(int v);
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    function automatic int mbyte(logic [23:0] packed_m, int c);
        return int'(packed_m[8*c +: 8]);
    endfunction

    function automatic pixel_result_t predict_pixel(req_type_t kind, int pix, int p[3],
                                                    logic masked);
        pixel_result_t r;
        int n, k, w, c, lo[3], hi[3];
        bit found, ok;
        codeword_t cw;
        logic [31:0] run;
        r.fg = 0;
        r.st = 0;
        n = count_of.exists(pix) ? int'(count_of[pix]) : 0;
        case (kind)
            REQ_UPDATE: if (!masked)
            begin
                found = 0;
                for (c = 0; c < 3; c++)
                begin
                    lo[c] = clip8(p[c] - mbyte(learn_m, c));
                    hi[c] = clip8(p[c] + mbyte(learn_m, c));
                end
                for (w = 0; w < n; w++)
                begin
                    cw = book[pix*8 + w];
                    ok = 1;
                    for (c = 0; c < 3; c++)
                        if (!(int'(cw.learn_min[c]) <= p[c] && p[c] <= int'(cw.learn_max[c])))
                            ok = 0;
                    if (!found && ok)
                    begin
                        cw.last_update = now;
                        for (c = 0; c < 3; c++)
                        begin
                            if (p[c] < int'(cw.box_min[c])) cw.box_min[c] = 8'(p[c]);
                            if (p[c] > int'(cw.box_max[c])) cw.box_max[c] = 8'(p[c]);
                            if (int'(cw.learn_min[c]) > lo[c]) cw.learn_min[c]--;
                            if (int'(cw.learn_max[c]) < hi[c]) cw.learn_max[c]++;
                        end
                        found = 1;
                    end
                    else
                    begin
                        run = now - cw.last_update;
                        if (run > cw.staleness) cw.staleness = run;
                    end
                    book[pix*8 + w] = cw;
                end
                if (!found)
                begin
                    if (n >= CBM_MAX_WORDS)
                        r.st = 1;
                    else
                    begin
                        for (w = n; w > 0; w--)
                            book[pix*8 + w] = book[pix*8 + w - 1];
                        for (c = 0; c < 3; c++)
                        begin
                            cw.learn_min[c] = 8'(lo[c]);
                            cw.learn_max[c] = 8'(hi[c]);
                            cw.box_min[c] = 8'(p[c]);
                            cw.box_max[c] = 8'(p[c]);
                        end
                        cw.last_update = now;
                        cw.staleness = 0;
                        book[pix*8] = cw;
                        n++;
                    end
                end
            end
            REQ_DIFF:
            begin
                r.fg = 1;
                for (w = 0; w < n; w++)
                begin
                    cw = book[pix*8 + w];
                    ok = 1;
                    for (c = 0; c < 3; c++)
                        if (!(int'(cw.box_min[c]) <= p[c] + mbyte(low_m, c) &&
                              p[c] - mbyte(high_m, c) <= int'(cw.box_max[c])))
                            ok = 0;
                    if (ok) r.fg = 0;
                end
            end
            REQ_CLEAR: if (!masked)
            begin
                k = 0;
                for (w = 0; w < n; w++)
                begin
                    cw = book[pix*8 + w];
                    if (cw.staleness > {1'b0, stale_lim}) continue;
                    cw.staleness = 0;
                    cw.last_update = now;
                    book[pix*8 + k] = cw;
                    k++;
                end
                n = k;
            end
            default: now++;
        endcase
        count_of[pix] = 4'(n);
        r.words = 7'(n);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t got, want;
        int p[3];
        if (!rst_n)
        begin
            learn_m = LEARN_MARGINS_RST;
            low_m = MATCH_LOW_RST;
            high_m = MATCH_HIGH_RST;
            stale_lim = STALE_THRESH_RST;
            now = 0;
            count_of.delete();
            book.delete();
            result_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                case (reg_index_t'(cfg.reg_index))
                    REG_LEARN_MARGINS: learn_m = cfg.wdata[23:0];
                    REG_MATCH_LOW:     low_m = cfg.wdata[23:0];
                    REG_MATCH_HIGH:    high_m = cfg.wdata[23:0];
                    default:           stale_lim = cfg.wdata[30:0];
                endcase
            if (res.valid && res.ready)
            begin
                got.fg = res.foreground;
                got.st = res.status;
                got.words = res.words_in_pixel;
                if (result_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result beat with nothing expected", $realtime);
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.fg !== want.fg || got.st !== want.st || got.words !== want.words)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch fg/status/words exp %0d/%0d/%0d got %b/%b/%0d",
                                     $realtime, want.fg, want.st, want.words,
                                     got.fg, got.st, got.words);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                p[0] = int'(req.chan0);
                p[1] = int'(req.chan1);
                p[2] = int'(req.chan2);
                result_q.push_back(predict_pixel(req_type_t'(req.req_type),
                                                 int'(req.pixel_index), p, req.masked_out));
            end
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import cbm_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   tx_idle_pct;
    int   rx_idle_pct;
    int   sent;
    int   received;
    int   base_of[12][3];

    const int pixel_pool[12] = '{0, 1, 2, 3, 5, 7, 16'hFFFF, 16'h8000, 16'h5555,
                                 16'hAAAA, 16'h1234, 16'hFEDC};

    cbm_cfg_if cfg ();
    cbm_req_if req ();
    cbm_res_if res ();

    codebook_background_model_core uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    tb_codebook_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .res        (res),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (res.valid && res.ready) received++;
    end

    always @(negedge clk)
    begin
        res.ready = ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_pixel(req_type_t kind, int pix, int c0, int c1, int c2, bit masked);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid = 0;
            @(negedge clk);
        end
        req.req_type = kind;
        req.pixel_index = 16'(pix);
        req.chan0 = 8'(c0);
        req.chan1 = 8'(c1);
        req.chan2 = 8'(c2);
        req.masked_out = masked;
        req.valid = 1;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        req.valid = 0;
        while (received != sent) @(negedge clk);
        repeat (5) @(negedge clk);
        cfg.reg_index = idx;
        cfg.wdata = value;
        cfg.valid = 1;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        @(negedge clk);
        cfg.valid = 0;
    endtask

    task automatic set_margins(logic [23:0] lm, logic [23:0] lo, logic [23:0] hi,
                               logic [30:0] lim);
        write_reg(REG_LEARN_MARGINS, {8'd0, lm});
        write_reg(REG_MATCH_LOW, {8'd0, lo});
        write_reg(REG_MATCH_HIGH, {8'd0, hi});
        write_reg(REG_STALE_THRESH, {1'b0, lim});
    endtask

    function automatic int jitter(int b);
        int v;
        v = b + $urandom_range(24) - 12;
        return v < 0 ? 0 : (v > 255 ? 255 : v);
    endfunction

    task automatic random_pixels(int count);
        int k, r, pix, c[3], i;
        req_type_t kind;
        for (i = 0; i < count; i++)
        begin
            k = $urandom_range(11);
            pix = ($urandom_range(19) == 0) ? $urandom_range(16'hFFFF) : pixel_pool[k];
            r = $urandom_range(99);
            kind = r < 45 ? REQ_UPDATE : r < 75 ? REQ_DIFF : r < 85 ? REQ_CLEAR : REQ_ADVANCE;
            for (int j = 0; j < 3; j++)
                c[j] = ($urandom_range(6) == 0) ? $urandom_range(255) : jitter(base_of[k][j]);
            send_pixel(kind, pix, c[0], c[1], c[2], $urandom_range(11) == 0);
        end
    endtask

    initial
    begin
        rst_n = 0;
        tx_idle_pct = 22;
        rx_idle_pct = 47;
        sent = 0;
        received = 0;
        req.valid = 0;
        req.req_type = REQ_UPDATE;
        req.pixel_index = 16'd0;
        req.chan0 = 8'd0;
        req.chan1 = 8'd0;
        req.chan2 = 8'd0;
        req.masked_out = 0;
        cfg.valid = 0;
        cfg.reg_index = REG_LEARN_MARGINS;
        cfg.wdata = 0;
        foreach (base_of[i, j]) base_of[i][j] = $urandom_range(255);
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        send_pixel(REQ_UPDATE, 0, 0, 0, 0, 0);
        send_pixel(REQ_UPDATE, 16'hFFFF, 255, 255, 255, 0);
        send_pixel(REQ_DIFF, 0, 0, 0, 0, 1);
        send_pixel(REQ_DIFF, 16'hFFFF, 255, 255, 255, 0);
        send_pixel(REQ_DIFF, 0, 255, 128, 77, 0);
        send_pixel(REQ_UPDATE, 2, 100, 100, 100, 1);
        send_pixel(REQ_ADVANCE, 16'hFFFF, 255, 255, 255, 1);
        for (int i = 0; i < 9; i++)
            send_pixel(REQ_UPDATE, 1, i * 30, 255 - i * 30, i * 7, 0);
        send_pixel(REQ_ADVANCE, 0, 0, 0, 0, 0);
        send_pixel(REQ_UPDATE, 1, 0, 255, 0, 0);
        send_pixel(REQ_CLEAR, 1, 0, 0, 0, 1);
        send_pixel(REQ_CLEAR, 1, 0, 0, 0, 0);
        send_pixel(REQ_DIFF, 1, 0, 255, 0, 0);
        send_pixel(REQ_CLEAR, 0, 0, 0, 0, 0);

        random_pixels(220);
        set_margins(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 31'h7FFFFFFF);
        random_pixels(220);
        tx_idle_pct = 47;
        rx_idle_pct = 22;
        set_margins(24'h000000, 24'h000000, 24'h000000, 31'd0);
        random_pixels(220);
        set_margins(24'h030405, 24'h020202, 24'h060103, 31'd3);
        random_pixels(220);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_margins(24'h0A0A0A, 24'h010103, 24'h01010A, 31'd1);
        random_pixels(220);
        set_margins(24'h201008, 24'h0F0F0F, 24'h0F0F0F, 31'd6);
        random_pixels(230);

        req.valid = 0;
        while (received != sent) @(negedge clk);
        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
